>>> src/mnst_pkg.sv
// mnst_pkg: shared types and codes for the midi note state tracker
// holds the event kind codes, the back end states, the queued command beat and the result beat
// no dependencies
`default_nettype none

package mnst_pkg;

	// event kinds as carried in the input tuser
	typedef enum logic [2:0] {
		KIND_NOTE_ON     = 3'd0,
		KIND_NOTE_OFF    = 3'd1,
		KIND_SUSTAIN_ON  = 3'd2,
		KIND_SUSTAIN_OFF = 3'd3,
		KIND_CTRL_CHANGE = 3'd4,
		KIND_PROG_CHANGE = 3'd5,
		KIND_QUERY       = 3'd6,
		KIND_CLEAR_ALL   = 3'd7
	} kind_t;

	// back end sequencing
	typedef enum logic [2:0] {
		BK_IDLE,
		BK_EXEC,
		BK_SWEEP,
		BK_DRAIN,
		BK_RESULT
	} bk_state_t;

	// classified event waiting for the back end
	typedef struct packed {
		kind_t       kind;
		logic        note_ok;
		logic        ctl_ok;
		logic [7:0]  note;
		logic [7:0]  vel;
		logic [31:0] ts;
		logic [7:0]  ctl;
		logic [7:0]  ccv;
		logic [7:0]  prog;
	} cmd_t;

	// one result beat
	typedef struct packed {
		logic       found;
		logic [6:0] recent_note;
		logic       active;
		logic [7:0] velocity;
		logic [7:0] ctl_value;
		logic [7:0] prog;
	} res_t;

	localparam int QueueDepth = 2;

endpackage

`default_nettype wire

>>> src/mnst_front.sv
// mnst_front: input side, unpacks and classifies each event beat
// depends on mnst_pkg for kind_t and cmd_t
`default_nettype none

module mnst_front
	import mnst_pkg::*;
#(
	parameter int NOTE_COUNT       = 128,
	parameter int CONTROLLER_COUNT = 128
) (
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [71:0] s_tdata,
	input  wire logic [2:0]  s_tuser,
	output logic             cmd_valid,
	input  wire logic        cmd_ready,
	output cmd_t             cmd
);

	// unpack fields and range-check note and controller numbers
	always_comb begin
		cmd.kind    = kind_t'(s_tuser);
		cmd.note    = s_tdata[7:0];
		cmd.vel     = s_tdata[15:8];
		cmd.ts      = s_tdata[47:16];
		cmd.ctl     = s_tdata[55:48];
		cmd.ccv     = s_tdata[63:56];
		cmd.prog    = s_tdata[71:64];
		cmd.note_ok = ({1'b0, s_tdata[7:0]} < 9'(NOTE_COUNT));
		cmd.ctl_ok  = ({1'b0, s_tdata[55:48]} < 9'(CONTROLLER_COUNT));
	end

	// beat handshake straight onto the queue
	assign cmd_valid = s_tvalid;
	assign s_tready  = cmd_ready;

endmodule

`default_nettype wire

>>> src/mnst_queue.sv
// mnst_queue: short command queue between the front and back ends
// depends on mnst_pkg for cmd_t and QueueDepth
`default_nettype none

module mnst_queue
	import mnst_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  cmd_t      in_cmd,
	output logic      out_valid,
	input  wire logic out_ready,
	output cmd_t      out_cmd
);

	localparam int PW = $clog2(QueueDepth);
	localparam int CW = $clog2(QueueDepth + 1);

	cmd_t          slot_q [QueueDepth];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          push;
	logic          pop;

	assign in_ready  = (count_q != CW'(QueueDepth));
	assign out_valid = (count_q != '0);
	assign out_cmd   = slot_q[rd_ptr_q];
	assign push      = in_valid & in_ready;
	assign pop       = out_valid & out_ready;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_cmd;
		end
	end

endmodule

`default_nettype wire

>>> src/mnst_back.sv
// mnst_back: executes queued events on the note and controller state,
// sweeps the note table for the newest active note and holds the result
// depends on mnst_pkg for kind_t, bk_state_t, cmd_t and res_t
`default_nettype none

module mnst_back
	import mnst_pkg::*;
#(
	parameter int NOTE_COUNT       = 128,
	parameter int CONTROLLER_COUNT = 128
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cmd_valid,
	output logic      cmd_ready,
	input  cmd_t      cmd,
	output logic      res_valid,
	input  wire logic res_ready,
	output res_t      res
);

	localparam int NW = (NOTE_COUNT > 1) ? $clog2(NOTE_COUNT) : 1;
	localparam int KW = (CONTROLLER_COUNT > 1) ? $clog2(CONTROLLER_COUNT) : 1;
	localparam int CW = $clog2(NOTE_COUNT + 1);

	bk_state_t state_q, state_d;

	cmd_t    cmd_q;
	logic    take_cmd;
	logic    exec_en;
	logic    sweep_en;
	logic    load_res;

	// per-note flags, cleared at once by reset or clear all
	logic [NOTE_COUNT-1:0]       down_q;
	logic [NOTE_COUNT-1:0]       sus_q;
	logic [NOTE_COUNT-1:0]       wr_q;
	logic [CONTROLLER_COUNT-1:0] ctlv_q;
	logic                        pedal_q;
	logic [7:0]                  prog_q;

	// payload memories, only meaningful where the matching flag is set
	logic [7:0]  vel_mem [NOTE_COUNT];
	logic [31:0] age_mem [NOTE_COUNT];
	logic [7:0]  ctl_mem [CONTROLLER_COUNT];

	logic [NW-1:0] nidx;
	logic [KW-1:0] cidx;

	// sweep
	logic [CW-1:0] cnt_q;
	logic          rd_vld_s1;
	logic [NW-1:0] rd_idx_s1;
	logic [31:0]   age_rd_s1;
	logic [7:0]    vel_rd_s1;
	logic [7:0]    ctl_rd_s1;
	logic          best_found_q;
	logic [31:0]   peak_age_q;
	logic [NW-1:0] best_idx_q;
	logic [31:0]   age_eff;
	logic          entry_act;
	logic [7:0]    best_ext;

	logic res_valid_q;
	res_t res_q;

	assign nidx = cmd_q.note[NW-1:0];
	assign cidx = cmd_q.ctl[KW-1:0];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (cmd_valid) begin
					state_d = BK_EXEC;
				end
			end
			BK_EXEC: state_d = BK_SWEEP;
			BK_SWEEP: begin
				if (cnt_q == CW'(NOTE_COUNT - 1)) begin
					state_d = BK_DRAIN;
				end
			end
			BK_DRAIN: state_d = BK_RESULT;
			BK_RESULT: begin
				if (!res_valid_q || res_ready) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		take_cmd = 1'b0;
		exec_en  = 1'b0;
		sweep_en = 1'b0;
		load_res = 1'b0;
		unique case (state_q)
			BK_IDLE:   take_cmd = cmd_valid;
			BK_EXEC:   exec_en  = 1'b1;
			BK_SWEEP:  sweep_en = 1'b1;
			BK_DRAIN:  ;
			BK_RESULT: load_res = !res_valid_q || res_ready;
			default:   ;
		endcase
	end

	assign cmd_ready = take_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// latch the popped command
	always_ff @(posedge clk) begin
		if (take_cmd) begin
			cmd_q <= cmd;
		end
	end

	// apply the event to the flags, pedal and program
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			down_q  <= '0;
			sus_q   <= '0;
			wr_q    <= '0;
			ctlv_q  <= '0;
			pedal_q <= 1'b0;
			prog_q  <= '0;
		end else if (exec_en) begin
			case (cmd_q.kind)
				KIND_NOTE_ON: begin
					if (cmd_q.note_ok) begin
						down_q[nidx] <= 1'b1;
						wr_q[nidx]   <= 1'b1;
					end
				end
				KIND_NOTE_OFF: begin
					if (cmd_q.note_ok) begin
						down_q[nidx] <= 1'b0;
						if (pedal_q) begin
							sus_q[nidx] <= 1'b1;
						end else begin
							sus_q[nidx] <= 1'b0;
							wr_q[nidx]  <= 1'b0;
						end
					end
				end
				KIND_SUSTAIN_ON: pedal_q <= 1'b1;
				KIND_SUSTAIN_OFF: begin
					// released sustained notes drop out entirely
					pedal_q <= 1'b0;
					sus_q   <= sus_q & down_q;
					wr_q    <= wr_q & ~(sus_q & ~down_q);
				end
				KIND_CTRL_CHANGE: begin
					if (cmd_q.ctl_ok) begin
						ctlv_q[cidx] <= 1'b1;
					end
				end
				KIND_PROG_CHANGE: prog_q <= cmd_q.prog;
				KIND_CLEAR_ALL: begin
					down_q  <= '0;
					sus_q   <= '0;
					wr_q    <= '0;
					ctlv_q  <= '0;
					pedal_q <= 1'b0;
					prog_q  <= '0;
				end
				default: ;
			endcase
		end
	end

	// memory writes
	always_ff @(posedge clk) begin
		if (exec_en && cmd_q.kind == KIND_NOTE_ON && cmd_q.note_ok) begin
			vel_mem[nidx] <= cmd_q.vel;
			age_mem[nidx] <= cmd_q.ts;
		end
		if (exec_en && cmd_q.kind == KIND_CTRL_CHANGE && cmd_q.ctl_ok) begin
			ctl_mem[cidx] <= cmd_q.ccv;
		end
	end

	// memory reads: one age per sweep step, plus the addressed entries
	always_ff @(posedge clk) begin
		if (sweep_en) begin
			age_rd_s1 <= age_mem[cnt_q[NW-1:0]];
			rd_idx_s1 <= cnt_q[NW-1:0];
			vel_rd_s1 <= vel_mem[nidx];
			ctl_rd_s1 <= ctl_mem[cidx];
		end
	end

	// sweep counter and read-valid pipe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= sweep_en;
			if (exec_en) begin
				cnt_q <= '0;
			end else if (sweep_en) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// running best: highest age, later index wins ties
	assign age_eff   = wr_q[rd_idx_s1] ? age_rd_s1 : 32'd0;
	assign entry_act = down_q[rd_idx_s1] | sus_q[rd_idx_s1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_found_q <= 1'b0;
			peak_age_q   <= '0;
			best_idx_q   <= '0;
		end else if (exec_en) begin
			best_found_q <= 1'b0;
			peak_age_q   <= '0;
			best_idx_q   <= '0;
		end else if (rd_vld_s1 && entry_act && (age_eff >= peak_age_q)) begin
			best_found_q <= 1'b1;
			peak_age_q   <= age_eff;
			best_idx_q   <= rd_idx_s1;
		end
	end

	assign best_ext = 8'(best_idx_q);

	// output register, decouples the sweep from the downstream side
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_res) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			res_q.found       <= best_found_q;
			res_q.recent_note <= best_found_q ? best_ext[6:0] : 7'd0;
			res_q.active      <= cmd_q.note_ok & (down_q[nidx] | sus_q[nidx]);
			res_q.velocity    <= (cmd_q.note_ok & wr_q[nidx]) ? vel_rd_s1 : 8'd0;
			res_q.ctl_value   <= (cmd_q.ctl_ok & ctlv_q[cidx]) ? ctl_rd_s1 : 8'd0;
			res_q.prog        <= prog_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

`default_nettype wire

>>> src/midi_note_state_tracker.sv
// midi_note_state_tracker: top level, front decode, command queue and back end
// depends on mnst_pkg, mnst_front, mnst_queue and mnst_back
//
// Each input beat is one parsed MIDI event (kind in tuser); each event gives
// exactly one result beat, in order. The front end decodes and range-checks
// the event and drops it into a two-entry queue, so it keeps taking beats
// while the back end works and while a finished result waits downstream,
// until the queue is full. The back end handles one event at a time: it pops
// the event, applies the update, sweeps the note age memory through its
// single read port for the newest active note, drains the read pipe and
// loads the output register, which waits while an earlier result is still
// held downstream. Reset clears all flags at once; no clearing pass is
// needed after reset.
`default_nettype none

module midi_note_state_tracker
	import mnst_pkg::*;
#(
	parameter int NOTE_COUNT       = 128,
	parameter int CONTROLLER_COUNT = 128
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// note_number[7:0], velocity[15:8], timestamp[47:16], controller[55:48],
	// cc_value[63:56], program_req[71:64]
	input  wire logic [71:0] s_tdata,
	// kind[2:0]
	input  wire logic [2:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// recent_found[0], recent_note[7:1], note_active[8], note_velocity[16:9],
	// controller_value[24:17], last_program[32:25], zero[39:33]
	output logic [39:0]      m_tdata
);

	cmd_t front_cmd;
	logic front_valid;
	logic front_ready;
	cmd_t back_cmd;
	logic back_valid;
	logic back_ready;
	res_t res;

	mnst_front #(
		.NOTE_COUNT       (NOTE_COUNT),
		.CONTROLLER_COUNT (CONTROLLER_COUNT)
	) u_front (
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cmd_valid (front_valid),
		.cmd_ready (front_ready),
		.cmd       (front_cmd)
	);

	mnst_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.in_ready  (front_ready),
		.in_cmd    (front_cmd),
		.out_valid (back_valid),
		.out_ready (back_ready),
		.out_cmd   (back_cmd)
	);

	mnst_back #(
		.NOTE_COUNT       (NOTE_COUNT),
		.CONTROLLER_COUNT (CONTROLLER_COUNT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (back_valid),
		.cmd_ready (back_ready),
		.cmd       (back_cmd),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res       (res)
	);

	// pack the result beat
	assign m_tdata = {7'd0, res.prog, res.ctl_value, res.velocity, res.active,
		res.recent_note, res.found};

endmodule

`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for midi_note_state_tracker, predicts every result beat
// from its own note table model and compares it field by field
// depends on mnst_pkg and the midi_note_state_tracker top level

module tb
	import mnst_pkg::*;
();

	localparam int NOTES       = 128;
	localparam int CONTROLLERS = 128;

	// expected content of one result beat
	typedef struct packed {
		logic       found;
		logic [6:0] recent_note;
		logic       active;
		logic [7:0] velocity;
		logic [7:0] ctl_value;
		logic [7:0] last_prog;
	} tracker_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [71:0] s_tdata;
	logic [2:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;

	// shared bench state
	bit              idle_enable;
	int              stall_request;
	int              mismatch_count;
	int              results_seen;
	logic [31:0]     clock_ts;
	tracker_result_t pending_results[$];

	// note table model
	bit          held[NOTES];
	bit          sustained[NOTES];
	logic [7:0]  note_vel[NOTES];
	logic [31:0] note_age[NOTES];
	logic [7:0]  ctl_table[CONTROLLERS];
	bit          pedal;
	logic [7:0]  prog_reg;

	midi_note_state_tracker u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit, far beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic void clear_note(input int idx);
		held[idx]      = 1'b0;
		sustained[idx] = 1'b0;
		note_vel[idx]  = '0;
		note_age[idx]  = '0;
	endfunction

	function automatic void clear_tracker();
		int i;
		for (i = 0; i < NOTES; i++)
			clear_note(i);
		for (i = 0; i < CONTROLLERS; i++)
			ctl_table[i] = '0;
		pedal    = 1'b0;
		prog_reg = '0;
	endfunction

	// applies one event to the model and forms the result it gives
	function automatic tracker_result_t apply_event(input kind_t kind, input logic [7:0] note,
			input logic [7:0] vel, input logic [31:0] ts, input logic [7:0] ctl,
			input logic [7:0] ccv, input logic [7:0] prog);
		tracker_result_t r;
		bit              note_ok;
		bit              ctl_ok;
		logic [6:0]      nidx;
		logic [6:0]      cidx;
		logic [31:0]     peak_age;
		int              i;
		note_ok = note < NOTES;
		ctl_ok  = ctl < CONTROLLERS;
		nidx    = note[6:0];
		cidx    = ctl[6:0];
		case (kind)
			KIND_NOTE_ON: begin
				if (note_ok) begin
					held[nidx]     = 1'b1;
					note_vel[nidx] = vel;
					note_age[nidx] = ts;
				end
			end
			KIND_NOTE_OFF: begin
				if (note_ok) begin
					if (pedal) begin
						held[nidx]      = 1'b0;
						sustained[nidx] = 1'b1;
					end else begin
						clear_note(int'(nidx));
					end
				end
			end
			KIND_SUSTAIN_ON: pedal = 1'b1;
			KIND_SUSTAIN_OFF: begin
				pedal = 1'b0;
				for (i = 0; i < NOTES; i++)
					if (!held[i] && sustained[i])
						clear_note(i);
			end
			KIND_CTRL_CHANGE: begin
				if (ctl_ok)
					ctl_table[cidx] = ccv;
			end
			KIND_PROG_CHANGE: prog_reg = prog;
			KIND_CLEAR_ALL: clear_tracker();
			default: ;
		endcase
		// newest active note, ties to the higher index
		r        = '0;
		peak_age = '0;
		for (i = 0; i < NOTES; i++) begin
			if ((held[i] || sustained[i]) && note_age[i] >= peak_age) begin
				peak_age      = note_age[i];
				r.recent_note = i[6:0];
				r.found       = 1'b1;
			end
		end
		r.active    = note_ok && (held[nidx] || sustained[nidx]);
		r.velocity  = note_ok ? note_vel[nidx] : 8'd0;
		r.ctl_value = ctl_ok ? ctl_table[cidx] : 8'd0;
		r.last_prog = prog_reg;
		return r;
	endfunction

	// offers one event beat; called at a rising edge, returns at the accepting edge
	task automatic send_event(input kind_t kind, input logic [7:0] note, input logic [7:0] vel,
			input logic [31:0] ts, input logic [7:0] ctl, input logic [7:0] ccv,
			input logic [7:0] prog);
		bit taken;
		while (idle_enable && $urandom_range(99) < 9) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {prog, ccv, ctl, ts, vel, note};
		taken = 1'b0;
		while (!taken) begin
			// inputs and ready are settled mid-cycle, so this decides the next edge
			@(negedge clk);
			taken = s_tready;
			if (taken)
				pending_results.push_back(apply_event(kind, note, vel, ts, ctl, ccv, prog));
			@(posedge clk);
		end
	endtask

	task automatic compare_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("result %0d: %s expected 0x%0h, got 0x%0h",
					results_seen, field, want, got);
		end
	endtask

	// result receiver: random idling plus a counted hold-off on request
	initial begin : result_sink
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (stall_request > 0) begin
				hold_left     = stall_request;
				stall_request = 0;
			end
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= !(idle_enable && $urandom_range(99) < 9);
			end
		end
	end

	// result checker, sampled mid-cycle ahead of the accepting edge
	initial begin : result_checker
		tracker_result_t want;
		forever begin
			@(negedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				if (pending_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("result %0d: unexpected beat 0x%h", results_seen, m_tdata);
				end else begin
					want = pending_results.pop_front();
					compare_field("recent_found", 32'(want.found), 32'(m_tdata[0]));
					compare_field("recent_note", 32'(want.recent_note), 32'(m_tdata[7:1]));
					compare_field("note_active", 32'(want.active), 32'(m_tdata[8]));
					compare_field("note_velocity", 32'(want.velocity), 32'(m_tdata[16:9]));
					compare_field("controller_value", 32'(want.ctl_value),
						32'(m_tdata[24:17]));
					compare_field("last_program", 32'(want.last_prog), 32'(m_tdata[32:25]));
					compare_field("padding", 32'd0, 32'(m_tdata[39:33]));
				end
				results_seen++;
			end
		end
	end

	// field extremes, range checks and the note, controller, program and query kinds
	task automatic test_extremes();
		send_event(KIND_QUERY, 8'd0, 8'd0, 32'd0, 8'd0, 8'd0, 8'd0);
		send_event(KIND_NOTE_ON, 8'd127, 8'd255, 32'hFFFF_FFFF, 8'd127, 8'd0, 8'd0);
		send_event(KIND_NOTE_ON, 8'd0, 8'd0, 32'd0, 8'd0, 8'd255, 8'd255);
		send_event(KIND_NOTE_ON, 8'd128, 8'hAA, 32'hFFFF_FFFF, 8'd1, 8'd0, 8'd0);
		send_event(KIND_QUERY, 8'd255, 8'hFF, 32'hFFFF_FFFF, 8'd255, 8'hFF, 8'hFF);
		send_event(KIND_CTRL_CHANGE, 8'd0, 8'd0, 32'd0, 8'd127, 8'd255, 8'd0);
		send_event(KIND_CTRL_CHANGE, 8'd127, 8'd0, 32'd0, 8'd128, 8'd55, 8'd0);
		send_event(KIND_CTRL_CHANGE, 8'd127, 8'd0, 32'd0, 8'd0, 8'h5A, 8'd0);
		send_event(KIND_PROG_CHANGE, 8'd0, 8'd0, 32'd0, 8'd127, 8'd0, 8'd255);
		send_event(KIND_PROG_CHANGE, 8'd127, 8'd0, 32'd0, 8'd0, 8'd0, 8'd0);
		send_event(KIND_NOTE_OFF, 8'd127, 8'd0, 32'd0, 8'd127, 8'd0, 8'd0);
		send_event(KIND_NOTE_OFF, 8'd0, 8'd0, 32'd0, 8'd0, 8'd0, 8'd0);
	endtask

	// pedal handling, sustained release, age ties and clear all
	task automatic test_sustain_rules();
		send_event(KIND_SUSTAIN_ON, 8'd0, 8'd0, 32'd0, 8'd0, 8'd0, 8'd0);
		send_event(KIND_NOTE_ON, 8'd60, 8'd100, 32'd10, 8'd0, 8'd0, 8'd0);
		send_event(KIND_NOTE_OFF, 8'd60, 8'd0, 32'd0, 8'd0, 8'd0, 8'd0);
		// release of a note that was never held still marks it sustained
		send_event(KIND_NOTE_OFF, 8'd5, 8'd0, 32'd0, 8'd0, 8'd0, 8'd0);
		send_event(KIND_NOTE_ON, 8'd60, 8'd90, 32'd20, 8'd0, 8'd0, 8'd0);
		// equal ages go to the higher note
		send_event(KIND_NOTE_ON, 8'd61, 8'd33, 32'd20, 8'd0, 8'd0, 8'd0);
		send_event(KIND_SUSTAIN_OFF, 8'd60, 8'd0, 32'd0, 8'd0, 8'd0, 8'd0);
		send_event(KIND_QUERY, 8'd5, 8'd0, 32'd0, 8'd0, 8'd0, 8'd0);
		send_event(KIND_NOTE_OFF, 8'd60, 8'd0, 32'd0, 8'd0, 8'd0, 8'd0);
		send_event(KIND_PROG_CHANGE, 8'd61, 8'd0, 32'd0, 8'd0, 8'd0, 8'd77);
		send_event(KIND_CTRL_CHANGE, 8'd61, 8'd0, 32'd0, 8'd3, 8'd9, 8'd0);
		send_event(KIND_CLEAR_ALL, 8'd61, 8'd0, 32'd0, 8'd3, 8'd0, 8'd0);
		send_event(KIND_QUERY, 8'd61, 8'd0, 32'd0, 8'd3, 8'd0, 8'd0);
	endtask

	// receiver holds off long enough for the queue to fill and stall the input
	task automatic test_output_stall();
		int         n;
		logic [7:0] note;
		stall_request = 2000;
		for (n = 0; n < 12; n++) begin
			note     = 8'(40 + n);
			clock_ts = clock_ts + 32'd1;
			if (n % 2 == 0)
				send_event(KIND_NOTE_ON, note, 8'($urandom_range(255)), clock_ts,
					8'($urandom_range(127)), 8'($urandom_range(255)),
					8'($urandom_range(255)));
			else
				send_event(KIND_QUERY, note, 8'($urandom_range(255)), $urandom(),
					8'($urandom_range(255)), 8'($urandom_range(255)),
					8'($urandom_range(255)));
		end
	endtask

	// random event traffic around a small pool of notes so that the table fills
	task automatic test_random_traffic(input int count, input bit with_idle);
		int          n;
		int          pick;
		kind_t       kind;
		logic [7:0]  note;
		logic [7:0]  ctl;
		logic [31:0] ts;
		idle_enable = with_idle;
		for (n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			if (pick < 28)      kind = KIND_NOTE_ON;
			else if (pick < 52) kind = KIND_NOTE_OFF;
			else if (pick < 60) kind = KIND_SUSTAIN_ON;
			else if (pick < 68) kind = KIND_SUSTAIN_OFF;
			else if (pick < 76) kind = KIND_CTRL_CHANGE;
			else if (pick < 82) kind = KIND_PROG_CHANGE;
			else if (pick < 97) kind = KIND_QUERY;
			else                kind = KIND_CLEAR_ALL;

			pick = $urandom_range(99);
			if (pick < 60)      note = 8'($urandom_range(71, 56));
			else if (pick < 88) note = 8'($urandom_range(127));
			else                note = 8'($urandom_range(255, 128));

			ctl = ($urandom_range(99) < 85) ? 8'($urandom_range(127)) :
				8'($urandom_range(255, 128));

			// mostly rising time with frequent ties, sometimes wild values
			pick = $urandom_range(99);
			if (pick < 80) begin
				clock_ts = clock_ts + $urandom_range(3);
				ts       = clock_ts;
			end else if (pick < 92) begin
				ts = $urandom();
			end else begin
				ts = ($urandom_range(1) != 0) ? 32'hFFFF_FFFF : 32'd0;
			end

			send_event(kind, note, 8'($urandom_range(255)), ts, ctl,
				8'($urandom_range(255)), 8'($urandom_range(255)));
		end
		idle_enable = 1'b1;
	endtask

	initial begin
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		s_tuser        = '0;
		m_tready       = 1'b0;
		idle_enable    = 1'b1;
		stall_request  = 0;
		mismatch_count = 0;
		results_seen   = 0;
		clock_ts       = 32'd1000;
		clear_tracker();

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_extremes();
		test_sustain_rules();
		test_random_traffic(360, 1'b1);
		test_output_stall();
		test_random_traffic(150, 1'b0);

		// drain every outstanding result, then allow for a stray beat
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);

		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

>>> sim.f
src/mnst_pkg.sv
src/mnst_front.sv
src/mnst_queue.sv
src/mnst_back.sv
src/midi_note_state_tracker.sv
bench/tb.sv
